[rtl/core/stepped_line_waypoint_generator_assert.svh]
// Assertion macros for the waypoint generator modules; slwg_ctrl uses them.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef STEPPED_LINE_WAYPOINT_GENERATOR_ASSERT_SVH
`define STEPPED_LINE_WAYPOINT_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SLWG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slwg: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SLWG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slwg: next-cycle check failed");

`endif

[rtl/core/slwg_pkg.sv]
package slwg_pkg;

  localparam int COORD_BITS    = 7;
  localparam int STEP_SIZE     = 4;
  localparam int MAX_WAYPOINTS = 32;

  // Three extra bits hold the sign and the minor-axis overshoot, and bound
  // the error term, which stays within four times the coordinate range.
  localparam int POS_W = COORD_BITS + 3;
  localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam pos_t POS_HI   = pos_t'((1 << COORD_BITS) - 1);
  localparam pos_t STEP_POS = pos_t'(STEP_SIZE);
  localparam cnt_t CNT_MAX  = cnt_t'(MAX_WAYPOINTS);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic emit_step;
    logic emit_end;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
  } dp_status_t;

  function automatic coord_t clamp_coord(pos_t v);
    if (v < 0) begin
      return '0;
    end else if (v > POS_HI) begin
      return '1;
    end else begin
      return v[COORD_BITS-1:0];
    end
  endfunction

endpackage

[rtl/core/slwg_datapath.sv]
module slwg_datapath (
  input  logic                 clk,
  input  slwg_pkg::dp_cmd_t    cmd,
  output slwg_pkg::dp_status_t status,
  input  slwg_pkg::coord_t     in_start_x,
  input  slwg_pkg::coord_t     in_start_y,
  input  slwg_pkg::coord_t     in_end_x,
  input  slwg_pkg::coord_t     in_end_y,
  output slwg_pkg::coord_t     out_point_x,
  output slwg_pkg::coord_t     out_point_y,
  output logic                 out_last_point
);

  // Walk state.
  slwg_pkg::pos_t   x_r, y_r, x_nxt, y_nxt;
  slwg_pkg::coord_t xe_r, ye_r;
  logic             x_major_r, x_up_r, y_up_r;
  slwg_pkg::pos_t   dmaj_r, dmin_r;
  slwg_pkg::pos_t   err_r, err_nxt;
  slwg_pkg::cnt_t   cnt_r;

  // Output word register.
  slwg_pkg::coord_t point_x_r, point_y_r;
  logic             last_r;

  // Request setup.
  slwg_pkg::pos_t sx, sy, ex, ey, dx, dy, adx, ady, dmaj, dmin, err_init;
  logic           x_major;

  // Step logic.
  slwg_pkg::pos_t maj_pos, maj_end, x_step, y_step;
  logic           maj_up, not_reached, minor_move;

  always_comb begin
    sx       = slwg_pkg::pos_t'(in_start_x);
    sy       = slwg_pkg::pos_t'(in_start_y);
    ex       = slwg_pkg::pos_t'(in_end_x);
    ey       = slwg_pkg::pos_t'(in_end_y);
    dx       = ex - sx;
    dy       = ey - sy;
    adx      = (dx < 0) ? -dx : dx;
    ady      = (dy < 0) ? -dy : dy;
    x_major  = (adx >= ady);
    dmaj     = x_major ? adx : ady;
    dmin     = x_major ? ady : adx;
    err_init = (dmin <<< 1) - dmaj;
  end

  always_comb begin
    maj_pos     = x_major_r ? x_r : y_r;
    maj_end     = x_major_r ? slwg_pkg::pos_t'(xe_r) : slwg_pkg::pos_t'(ye_r);
    maj_up      = x_major_r ? x_up_r : y_up_r;
    not_reached = maj_up ? (maj_pos < maj_end) : (maj_pos > maj_end);
    status.more = not_reached && (cnt_r < slwg_pkg::CNT_MAX);

    // The minor axis moves whenever the error term is not negative.
    minor_move = !err_r[slwg_pkg::POS_W-1];
    x_step     = x_up_r ? (x_r + slwg_pkg::STEP_POS) : (x_r - slwg_pkg::STEP_POS);
    y_step     = y_up_r ? (y_r + slwg_pkg::STEP_POS) : (y_r - slwg_pkg::STEP_POS);
    x_nxt      = (x_major_r || minor_move) ? x_step : x_r;
    y_nxt      = (!x_major_r || minor_move) ? y_step : y_r;
    err_nxt    = err_r + (dmin_r <<< 1) - (minor_move ? (dmaj_r <<< 1) : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r       <= sx;
      y_r       <= sy;
      xe_r      <= in_end_x;
      ye_r      <= in_end_y;
      x_up_r    <= (dx > 0);
      y_up_r    <= (dy > 0);
      x_major_r <= x_major;
      dmaj_r    <= dmaj;
      dmin_r    <= dmin;
      err_r     <= err_init;
      cnt_r     <= '0;
    end else if (cmd.emit_step) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      point_x_r <= slwg_pkg::clamp_coord(x_r);
      point_y_r <= slwg_pkg::clamp_coord(y_r);
      last_r    <= 1'b0;
    end else if (cmd.emit_end) begin
      point_x_r <= xe_r;
      point_y_r <= ye_r;
      last_r    <= 1'b1;
    end
  end

  assign out_point_x    = point_x_r;
  assign out_point_y    = point_y_r;
  assign out_last_point = last_r;

endmodule

[rtl/core/slwg_ctrl.sv]
`include "stepped_line_waypoint_generator_assert.svh"

module slwg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  slwg_pkg::dp_status_t status,
  output slwg_pkg::dp_cmd_t    cmd
);

  slwg_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slwg_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = slwg_pkg::S_RUN;
        end
      end
      slwg_pkg::S_RUN: begin
        if (out_free && !status.more) begin
          state_nxt = slwg_pkg::S_IDLE;
        end
      end
      default: state_nxt = slwg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.load      = 1'b0;
    cmd.emit_step = 1'b0;
    cmd.emit_end  = 1'b0;
    unique case (state_r)
      slwg_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      slwg_pkg::S_RUN: begin
        cmd.emit_step = out_free && status.more;
        cmd.emit_end  = out_free && !status.more;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    if (cmd.emit_step || cmd.emit_end) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slwg_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `SLWG_ASSERT_NOW(a_load_excl_emit, cmd.load, !(cmd.emit_step || cmd.emit_end))
  `SLWG_ASSERT_NEXT(a_load_starts_run, cmd.load, state_r == slwg_pkg::S_RUN)
  `SLWG_ASSERT_NEXT(a_end_word_shown, cmd.emit_end, out_valid_r && state_r == slwg_pkg::S_IDLE)
  `SLWG_ASSERT_NOW(a_no_overwrite, out_valid_r && out_stall, !(cmd.emit_step || cmd.emit_end))

endmodule

[rtl/core/stepped_line_waypoint_generator.sv]
// Stepped line waypoint generator.
// Input channel: one word is a line request (start x/y, end x/y), taken
// when in_valid is high and in_stall is low. in_stall is high while a line
// is being walked and low otherwise.
// Result channel: a run of waypoints along the line, taken when out_valid
// is high and out_stall is low. The major axis advances 4 pixels per point,
// the minor axis 4 pixels when the Bresenham error is not negative. The
// exact end point comes last with out_last_point set.
// The first point is loaded into the walk registers when the request is
// taken, and is then written to the output register once that is free.
// Throughput: one point per cycle from the walk register and step adders
// while the receiver does not stall; a line gives at most 33 points.
// The next request is taken as soon as the end point is in the output
// register, even while that word still waits to be taken.
// When the receiver stalls, the output word holds and the walk pauses.
// Reset (rst_n low, synchronous) empties the output register and returns
// the block to idle; a line in progress is dropped.
module stepped_line_waypoint_generator (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  slwg_pkg::coord_t in_start_x,
  input  slwg_pkg::coord_t in_start_y,
  input  slwg_pkg::coord_t in_end_x,
  input  slwg_pkg::coord_t in_end_y,
  output logic             out_valid,
  input  logic             out_stall,
  output slwg_pkg::coord_t out_point_x,
  output slwg_pkg::coord_t out_point_y,
  output logic             out_last_point
);

  slwg_pkg::dp_cmd_t    cmd;
  slwg_pkg::dp_status_t status;

  slwg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  slwg_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point)
  );

endmodule
